/* rtl/sawc_pkg.sv */
// Shared types and constants for the set-associative write-back cache.
package sawc_pkg;
  localparam int ADDR_BITS  = 18;
  localparam int SETS       = 64;
  localparam int WAYS       = 4;
  localparam int SET_BITS   = $clog2(SETS);
  localparam int WAY_BITS   = $clog2(WAYS);
  localparam int TAG_BITS   = ADDR_BITS - 6 - SET_BITS;
  localparam int LINE_BITS  = ADDR_BITS - 6;
  localparam int MEM_LINES  = 1 << LINE_BITS;
  localparam int LINE_W     = 128;
  localparam int CACHE_DEPTH = SETS * WAYS;
  localparam int CIDX_BITS  = $clog2(CACHE_DEPTH);

  localparam logic [1:0] ST_INVALID  = 2'd0;
  localparam logic [1:0] ST_VALID    = 2'd1;
  localparam logic [1:0] ST_MODIFIED = 2'd3;
  localparam logic [1:0] PRIO_EMPTY  = 2'd3;
  localparam logic [1:0] PRIO_INSERT = 2'd2;
  localparam logic [1:0] PRIO_HIT    = 2'd0;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] address;
    logic signed [31:0]   write_data;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               hit;
    logic               wrote_back;
  } out_item_t;

  // Tag, status and priority of one way; a set's entries share one RAM word.
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          stat;
    logic [1:0]          prio;
  } way_meta_t;

  typedef way_meta_t [WAYS-1:0] set_meta_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic                op;
    logic [TAG_BITS-1:0] tag;
    logic [TAG_BITS-1:0] vtag;
    logic [SET_BITS-1:0] set;
    logic [1:0]          word;
    logic [31:0]         wdata;
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                dirty;
  } req_t;
endpackage

/* rtl/set_assoc_writeback_cache_rrip.sv */
// A 4-way, 64-set write-back, write-allocate cache with static re-reference
// priorities and an internal zero-initialised backing memory. Both sides are
// queues: push/full for accesses, empty/pop for one result per access. After
// reset the backing memory is cleared, one line a cycle, while full stays
// high. The front end takes an access and classifies it in the next cycle
// from the set's metadata RAM, and takes no new access until it is done; a
// two-entry queue decouples it from the back end. The back end sets the
// rate: it dequeues and reads the line and the fill line, captures them,
// writes back a modified victim if there is one, then updates the line data
// and presents the result. It takes no new access while one is in flight,
// and it holds while an earlier result waits to be popped.
module set_assoc_writeback_cache_rrip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  sawc_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output sawc_pkg::out_item_t out_item
);
  import sawc_pkg::*;

  logic    f_valid, q_pop, busy_clear, q_full;
  req_t    f_req, b_req;
  req_t    q_r [2];
  logic    rd_r, wr_r;
  logic [1:0] cnt_r;

  assign q_full = cnt_r == 2'd2;
  assign b_req  = q_r[rd_r];

  sawc_front u_front (
    .clk, .rst_n, .in_push, .in_item, .in_full, .req_valid(f_valid), .req(f_req),
    .q_full, .busy_clear);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (f_valid) begin
        q_r[wr_r] <= f_req;
        wr_r <= !wr_r;
      end
      if (q_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(f_valid) - 2'(q_pop);
    end
  end

  sawc_back u_back (
    .clk, .rst_n, .q_valid(cnt_r != 2'd0), .q_req(b_req),
    .q_pop, .out_empty, .out_pop, .out_item, .busy_clear);

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) busy_clear |-> in_full)
    else $error("accepted during clear");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> cnt_r != 2'd0)
    else $error("queue underflow");
endmodule

/* rtl/sawc_ram.sv */
// Generic single-port-write, registered-read RAM.
module sawc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sawc_front.sv */
// Front end: set metadata lookup, hit detection, victim choice.
module sawc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  sawc_pkg::in_item_t in_item,
  output logic               in_full,
  output logic               req_valid,
  output sawc_pkg::req_t     req,
  input  logic               q_full,
  input  logic               busy_clear
);
  import sawc_pkg::*;

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t              state_r;
  in_item_t            item_r;
  logic [SET_BITS-1:0] clr_r;

  set_meta_t           meta_rd, meta_wr;
  logic                meta_we;
  logic [SET_BITS-1:0] meta_waddr, meta_raddr;

  logic [SET_BITS-1:0]  set;
  logic [TAG_BITS-1:0]  tag;
  logic                 hit;
  logic [WAY_BITS-1:0]  hway, vway, way;
  logic [1:0]           best;
  logic                 acc;

  sawc_ram #(.WIDTH($bits(set_meta_t)), .DEPTH(SETS)) u_meta (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wr), .raddr(meta_raddr),
    .rdata(meta_rd));

  // Take one access, then look up its set before taking another; the queue has room by then.
  assign in_full    = busy_clear || q_full || state_r != S_IDLE;
  assign acc        = in_push && !in_full;
  assign meta_raddr = in_item.address[6 +: SET_BITS];
  assign set        = item_r.address[6 +: SET_BITS];
  assign tag        = item_r.address[ADDR_BITS-1 -: TAG_BITS];
  assign meta_we    = busy_clear || state_r == S_LOOK;
  assign meta_waddr = busy_clear ? clr_r : set;

  always_comb begin
    hit  = 1'b0;
    hway = '0;
    vway = '0;
    best = meta_rd[0].prio;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (meta_rd[w].tag == tag && meta_rd[w].stat != ST_INVALID) begin
        hit  = 1'b1;
        hway = WAY_BITS'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (meta_rd[w].prio > best) begin
        best = meta_rd[w].prio;
        vway = WAY_BITS'(w);
      end
    end
    way = hit ? hway : vway;
    meta_wr = meta_rd;
    meta_wr[way].tag  = tag;
    meta_wr[way].prio = hit ? PRIO_HIT : PRIO_INSERT;
    if (item_r.op == OP_WRITE)  meta_wr[way].stat = ST_MODIFIED;
    else if (!hit)              meta_wr[way].stat = ST_VALID;
    if (busy_clear) begin
      for (int w = 0; w < WAYS; w++) begin
        meta_wr[w] = '{tag: '0, stat: ST_INVALID, prio: PRIO_EMPTY};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clr_r   <= '0;
    end else begin
      if (busy_clear) clr_r <= clr_r + 1'b1;
      case (state_r)
        S_IDLE: if (acc) begin
          item_r  <= in_item;
          state_r <= S_LOOK;
        end
        S_LOOK: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign req_valid  = state_r == S_LOOK;
  assign req.op     = item_r.op;
  assign req.tag    = tag;
  assign req.vtag   = meta_rd[vway].tag;
  assign req.set    = set;
  assign req.word   = item_r.address[5:4];
  assign req.wdata  = item_r.write_data;
  assign req.hit    = hit;
  assign req.way    = way;
  assign req.dirty  = !hit && meta_rd[vway].stat == ST_MODIFIED;

  assert property (@(posedge clk) disable iff (!rst_n) req_valid |-> !q_full)
    else $error("request queue full on hand-over");
  assert property (@(posedge clk) disable iff (!rst_n) acc |=> state_r == S_LOOK)
    else $error("lookup did not follow transfer");
  assert property (@(posedge clk) disable iff (!rst_n) busy_clear |-> !acc)
    else $error("access taken during clear");
endmodule

/* rtl/sawc_back.sv */
// Back end: line data and backing memory, writeback, fill, word access.
module sawc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sawc_pkg::req_t      q_req,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output sawc_pkg::out_item_t out_item,
  output logic                busy_clear
);
  import sawc_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WB, S_FILL, S_DONE} state_t;

  state_t               state_r;
  req_t                 cur_r;
  logic [LINE_BITS:0]   clr_r;
  logic                 ovalid_r;
  out_item_t            oitem_r;
  logic [LINE_W-1:0]    line_r;

  logic                 dwe;
  logic [CIDX_BITS-1:0] didx;
  logic [LINE_W-1:0]    dwdata, drdata;
  logic                 mwe;
  logic [LINE_BITS-1:0] mwaddr, mraddr;
  logic [LINE_W-1:0]    mwdata, mrdata;
  logic [LINE_W-1:0]    merged;

  sawc_ram #(.WIDTH(LINE_W), .DEPTH(CACHE_DEPTH)) u_data (
    .clk, .we(dwe), .waddr(didx), .wdata(dwdata), .raddr(didx), .rdata(drdata));
  sawc_ram #(.WIDTH(LINE_W), .DEPTH(MEM_LINES)) u_mem (
    .clk, .we(mwe), .waddr(mwaddr), .wdata(mwdata), .raddr(mraddr), .rdata(mrdata));

  // Address the line of the queue head at dequeue, then hold the current one.
  assign didx = (state_r == S_IDLE) ? {q_req.set, q_req.way} : {cur_r.set, cur_r.way};
  assign mraddr = {q_req.tag, q_req.set};

  always_comb begin
    merged = line_r;
    if (cur_r.op == OP_WRITE) merged[cur_r.word*32 +: 32] = cur_r.wdata;
  end

  always_comb begin
    dwe = 1'b0; dwdata = merged;
    mwe = 1'b0; mwaddr = {cur_r.vtag, cur_r.set}; mwdata = drdata;
    case (state_r)
      S_CLEAR: begin
        mwe = 1'b1; mwaddr = clr_r[LINE_BITS-1:0]; mwdata = '0;
      end
      S_WB:   mwe = 1'b1;
      S_DONE: dwe = cur_r.op == OP_WRITE || !cur_r.hit;
      default: ;
    endcase
  end

  assign q_pop      = state_r == S_IDLE && q_valid && !ovalid_r;
  assign busy_clear = state_r == S_CLEAR;
  assign out_empty  = !ovalid_r;
  assign out_item   = oitem_r;

  // Miss line is read from the backing memory at dequeue; the writeback
  // cannot alias it since the victim tag differs from the requested one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_pop) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (LINE_BITS+1)'(MEM_LINES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (q_pop) begin
          cur_r   <= q_req;
          state_r <= S_READ;
        end
        S_READ: begin
          line_r  <= cur_r.hit ? drdata : mrdata;
          state_r <= cur_r.dirty ? S_WB : S_DONE;
        end
        S_WB: state_r <= S_DONE;
        S_DONE: begin
          oitem_r.read_data  <= cur_r.op == OP_WRITE ? 32'sd0
                                : $signed(line_r[cur_r.word*32 +: 32]);
          oitem_r.hit        <= cur_r.hit;
          oitem_r.wrote_back <= cur_r.dirty;
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> state_r == S_READ)
    else $error("dequeue did not start");
  assert property (@(posedge clk) disable iff (!rst_n) dwe |-> state_r == S_DONE)
    else $error("data write outside completion");
  assert property (@(posedge clk) disable iff (!rst_n) mwe && state_r != S_CLEAR |-> cur_r.dirty)
    else $error("writeback of clean line");
endmodule

/* test/tb_set_assoc_writeback_cache_rrip.sv */
// Self-checking testbench for the 4-way write-back cache with re-reference priorities.
module tb_set_assoc_writeback_cache_rrip;
  import sawc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  // Shadow copy of the cache and its backing memory
  logic [TAG_BITS-1:0] shadow_tag  [SETS][WAYS];
  logic [1:0]          shadow_stat [SETS][WAYS];
  logic [1:0]          shadow_prio [SETS][WAYS];
  logic [LINE_W-1:0]   shadow_line [SETS][WAYS];
  logic [LINE_W-1:0]   shadow_mem  [MEM_LINES];

  out_item_t pending_results[$];
  int  error_count = 0;
  int  accepted_count = 0;
  int  checked_count = 0;
  int  hit_count = 0;
  int  writeback_count = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;
  int  rx_hold_request = 0;
  int  rx_hold_left = 0;

  set_assoc_writeback_cache_rrip DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always #2 clk = ~clk;

  function automatic out_item_t cache_access(input in_item_t acc);
    out_item_t res;
    logic [TAG_BITS-1:0] tg;
    logic [SET_BITS-1:0] st;
    logic [1:0] wd;
    int victim;
    bit found;
    res = '0;
    found = 1'b0;
    tg = acc.address[ADDR_BITS-1 -: TAG_BITS];
    st = acc.address[6 +: SET_BITS];
    wd = acc.address[5:4];
    for (int w = 0; w < WAYS; w++) begin
      if (!found && shadow_stat[st][w] != ST_INVALID && shadow_tag[st][w] == tg) begin
        found = 1'b1;
        res.hit = 1'b1;
        shadow_prio[st][w] = PRIO_HIT;
        if (acc.op == OP_WRITE) begin
          shadow_stat[st][w] = ST_MODIFIED;
          shadow_line[st][w][wd*32 +: 32] = acc.write_data;
        end else begin
          res.read_data = shadow_line[st][w][wd*32 +: 32];
        end
      end
    end
    if (!found) begin
      victim = 0;
      for (int w = 1; w < WAYS; w++)
        if (shadow_prio[st][w] > shadow_prio[st][victim]) victim = w;
      if (shadow_stat[st][victim] == ST_MODIFIED) begin
        shadow_mem[{shadow_tag[st][victim], st}] = shadow_line[st][victim];
        res.wrote_back = 1'b1;
      end
      shadow_line[st][victim] = shadow_mem[{tg, st}];
      shadow_tag[st][victim] = tg;
      shadow_prio[st][victim] = PRIO_INSERT;
      if (acc.op == OP_WRITE) begin
        shadow_line[st][victim][wd*32 +: 32] = acc.write_data;
        shadow_stat[st][victim] = ST_MODIFIED;
      end else begin
        shadow_stat[st][victim] = ST_VALID;
        res.read_data = shadow_line[st][victim][wd*32 +: 32];
      end
    end
    return res;
  endfunction

  // Offer one access, hold it until the transfer, then maybe idle
  task automatic send_access(input logic op, input logic [ADDR_BITS-1:0] addr,
                             input logic [31:0] data);
    in_item_t it;
    it.op = op;
    it.address = addr;
    it.write_data = data;
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    pending_results.push_back(cache_access(it));
    accepted_count++;
    if (!steady && $urandom_range(99) < 16) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic stop_and_drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: check each transfer, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        error_count++;
      end else begin
        out_item_t exp_res;
        exp_res = pending_results.pop_front();
        checked_count++;
        if (out_item.hit) hit_count++;
        if (out_item.wrote_back) writeback_count++;
        if (out_item.read_data !== exp_res.read_data)
          $display("%0t: read_data expected %h actual %h", $time,
                   exp_res.read_data, out_item.read_data);
        if (out_item.hit !== exp_res.hit)
          $display("%0t: hit expected %b actual %b", $time, exp_res.hit, out_item.hit);
        if (out_item.wrote_back !== exp_res.wrote_back)
          $display("%0t: wrote_back expected %b actual %b", $time,
                   exp_res.wrote_back, out_item.wrote_back);
        if (out_item !== exp_res) error_count++;
      end
    end
    if (rx_hold_request != 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady || $urandom_range(99) >= 16;
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    logic [ADDR_BITS-1:0] base;
    send_access(OP_READ, '0, 32'h1234_5678);
    send_access(OP_WRITE, {ADDR_BITS{1'b1}}, 32'h7FFF_FFFF);
    send_access(OP_READ, {ADDR_BITS{1'b1}}, '0);
    send_access(OP_WRITE, 18'h3FFC0, 32'h8000_0000);
    send_access(OP_READ, 18'h3FFC0, 32'hFFFF_FFFF);
    send_access(OP_READ, 18'h3FFCF, '0);
    // Fill one set with four tags, hit them all, then force an eviction of way 0
    base = 18'h00140;
    for (int t = 1; t <= 4; t++)
      send_access(OP_WRITE, ADDR_BITS'(base | (t << 12) | (t[1:0] << 4)),
                  32'hA000_0000 + t);
    for (int t = 1; t <= 4; t++)
      send_access(OP_READ, ADDR_BITS'(base | (t << 12) | (t[1:0] << 4)), '0);
    send_access(OP_READ, ADDR_BITS'(base | (5 << 12)), '0);
    send_access(OP_READ, ADDR_BITS'(base | (1 << 12) | (1 << 4)), '0);
    send_access(OP_WRITE, ADDR_BITS'(base | (6 << 12)), 32'hFFFF_FFFE);
    send_access(OP_READ, ADDR_BITS'(base | (2 << 12) | (2 << 4)), '0);
    stop_and_drain();
  endtask

  task automatic test_random(input int count);
    logic [ADDR_BITS-1:0] addr;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 3 + 120);
      if ($urandom_range(99) < 70) begin
        // Few sets and tags so that hits, conflicts and writebacks are frequent
        addr = ADDR_BITS'($urandom);
        addr[ADDR_BITS-1 -: TAG_BITS] = TAG_BITS'($urandom_range(0, 7)) ^
                                        ($urandom_range(1) ? '1 : '0);
        addr[6 +: SET_BITS] = SET_BITS'($urandom_range(0, 3));
      end else begin
        addr = ADDR_BITS'($urandom);
      end
      send_access(1'($urandom_range(1)), addr, $urandom);
    end
    steady = 1'b0;
    stop_and_drain();
  endtask

  task automatic test_backpressure();
    rx_hold_request = 300;
    for (int i = 0; i < 16; i++)
      send_access(1'($urandom_range(1)), ADDR_BITS'($urandom), $urandom);
    stop_and_drain();
  endtask

  initial begin
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        shadow_tag[s][w] = '0;
        shadow_stat[s][w] = ST_INVALID;
        shadow_prio[s][w] = PRIO_EMPTY;
        shadow_line[s][w] = '0;
      end
    for (int m = 0; m < MEM_LINES; m++) shadow_mem[m] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(650);
    repeat (40) @(posedge clk);
    $display("covered %0d accesses: %0d hits, %0d writebacks, incl. a long result stall",
             accepted_count, hit_count, writeback_count);
    $display("%0d results checked, %0d mismatches", checked_count, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
